// ===== hw/rtl/lhbp_pkg.sv =====
// Package for the local-history (PAg) branch predictor.
// Holds table sizes, derived widths, command codes and the controller state type.
// No dependencies.
package lhbp_pkg;

	localparam int LOCAL_ENTRIES   = 1024;
	localparam int HISTORY_BITS    = 10;
	localparam int COUNTER_BITS    = 2;
	localparam int ADDR_SHIFT      = 2;
	localparam int ADDR_WIDTH      = 64;

	localparam int PATTERN_ENTRIES = 1 << HISTORY_BITS;
	localparam int SLOT_BITS       = (LOCAL_ENTRIES > 1) ? $clog2(LOCAL_ENTRIES) : 1;
	localparam int CLEAR_COUNT     = (LOCAL_ENTRIES > PATTERN_ENTRIES) ?
		LOCAL_ENTRIES : PATTERN_ENTRIES;
	localparam int CLEAR_BITS      = $clog2(CLEAR_COUNT);

	localparam logic CMD_LOOKUP    = 1'b0;
	localparam logic CMD_UPDATE    = 1'b1;

	typedef logic [HISTORY_BITS-1:0] hist_t;
	typedef logic [COUNTER_BITS-1:0] ctr_t;
	typedef logic [SLOT_BITS-1:0]    slot_t;
	typedef logic [CLEAR_BITS-1:0]   clear_idx_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ_PAT,
		ST_UPDATE
	} state_t;

endpackage

// ===== hw/rtl/local_history_branch_predictor.sv =====
// The block takes a new item only in its idle state, once the previous item has been
// committed; an item waits to commit while the result register is held full.
// The history table is read on the input transfer, then the pattern table is read,
// then the result register is loaded and, for an unsquashed update, both tables are written.
// Reset: both tables are swept to zero, one entry a cycle, for the larger of
// the two table depths, with in_ready low throughout. Depends on lhbp_pkg.
module local_history_branch_predictor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           cmd,
	input  logic [lhbp_pkg::ADDR_WIDTH-1:0] branch_address,
	input  logic                           outcome_taken,
	input  logic                           is_squashed,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           predict_taken
);

	lhbp_pkg::hist_t hist_mem [lhbp_pkg::LOCAL_ENTRIES];
	lhbp_pkg::ctr_t  pat_mem  [lhbp_pkg::PATTERN_ENTRIES];

	lhbp_pkg::state_t     state_q, state_d;
	lhbp_pkg::clear_idx_t clr_q;
	logic                 out_valid_q;
	logic                 predict_q;

	// Item held for the duration of its work
	lhbp_pkg::slot_t      slot_s1;
	logic                 upd_s1;
	logic                 taken_s1;
	lhbp_pkg::hist_t      hist_rd_s1;
	lhbp_pkg::ctr_t       ctr_rd_s2;

	lhbp_pkg::slot_t      in_slot;
	logic                 in_xfer;
	logic                 commit;
	logic                 clr_last;
	lhbp_pkg::ctr_t       ctr_new;
	lhbp_pkg::hist_t      hist_new;

	localparam lhbp_pkg::ctr_t CTR_MAX = {lhbp_pkg::COUNTER_BITS{1'b1}};

	assign in_slot = lhbp_pkg::SLOT_BITS'((branch_address >> lhbp_pkg::ADDR_SHIFT) &
		lhbp_pkg::ADDR_WIDTH'(lhbp_pkg::LOCAL_ENTRIES - 1));
	assign in_xfer  = in_valid && in_ready;
	assign clr_last = (clr_q == lhbp_pkg::CLEAR_BITS'(lhbp_pkg::CLEAR_COUNT - 1));

	always_comb begin
		if (taken_s1) begin
			ctr_new = (ctr_rd_s2 == CTR_MAX) ? ctr_rd_s2 : ctr_rd_s2 + 1'b1;
		end else begin
			ctr_new = (ctr_rd_s2 == '0) ? ctr_rd_s2 : ctr_rd_s2 - 1'b1;
		end
		hist_new = lhbp_pkg::HISTORY_BITS'({hist_rd_s1, taken_s1});
	end

	// Controller
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		commit   = 1'b0;
		unique case (state_q)
			lhbp_pkg::ST_CLEAR: begin
				if (clr_last) begin
					state_d = lhbp_pkg::ST_IDLE;
				end
			end
			lhbp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = lhbp_pkg::ST_READ_PAT;
				end
			end
			lhbp_pkg::ST_READ_PAT: begin
				state_d = lhbp_pkg::ST_UPDATE;
			end
			lhbp_pkg::ST_UPDATE: begin
				// hold until the result register is free
				if (!out_valid_q || out_ready) begin
					commit  = 1'b1;
					state_d = lhbp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lhbp_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lhbp_pkg::ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lhbp_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item capture and result register
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			slot_s1  <= in_slot;
			upd_s1   <= (cmd == lhbp_pkg::CMD_UPDATE) && !is_squashed;
			taken_s1 <= outcome_taken;
		end
		if (commit) begin
			predict_q <= ctr_rd_s2[lhbp_pkg::COUNTER_BITS-1];
		end
	end

	// History table: read on transfer, write on an update commit or during the sweep
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			hist_rd_s1 <= hist_mem[in_slot];
		end
		if (state_q == lhbp_pkg::ST_CLEAR) begin
			if (32'(clr_q) < lhbp_pkg::LOCAL_ENTRIES) begin
				hist_mem[clr_q[lhbp_pkg::SLOT_BITS-1:0]] <= '0;
			end
		end else if (commit && upd_s1) begin
			hist_mem[slot_s1] <= hist_new;
		end
	end

	// Pattern table: read once the history is known
	always_ff @(posedge clk) begin
		if (state_q == lhbp_pkg::ST_READ_PAT) begin
			ctr_rd_s2 <= pat_mem[hist_rd_s1];
		end
		if (state_q == lhbp_pkg::ST_CLEAR) begin
			if (32'(clr_q) < lhbp_pkg::PATTERN_ENTRIES) begin
				pat_mem[clr_q[lhbp_pkg::HISTORY_BITS-1:0]] <= '0;
			end
		end else if (commit && upd_s1) begin
			pat_mem[hist_rd_s1] <= ctr_new;
		end
	end

	assign out_valid     = out_valid_q;
	assign predict_taken = predict_q;

endmodule
